// ===== hw/rtl/u16u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

    localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
    localparam logic [15:0] SURR_HIGH_HI = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_HI  = 16'hDFFF;
    localparam logic [15:0] NONCHAR_FFFE = 16'hFFFE;
    localparam logic [15:0] NONCHAR_FFFF = 16'hFFFF;
    localparam logic [15:0] LIMIT_1BYTE  = 16'h0080;
    localparam logic [15:0] LIMIT_2BYTE  = 16'h0800;
    localparam logic [7:0]  LEAD_2BYTE   = 8'hC0;
    localparam logic [7:0]  LEAD_3BYTE   = 8'hE0;
    localparam logic [7:0]  LEAD_4BYTE   = 8'hF0;
    localparam logic [7:0]  CONT_BYTE    = 8'h80;
    localparam logic [10:0] PLANE_OFFSET = 11'h040;

    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned IDX_W     = 2;

    // Bytes produced by one code unit, waiting to be sent one per beat
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      last;
        logic                      err;
    } group_t;

endpackage

`default_nettype wire

// ===== hw/rtl/u16u8_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u16u8_encoder (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [15:0]       code_unit,
    input  wire logic              last_unit,
    output u16u8_pkg::group_t      group
);
    import u16u8_pkg::*;

    logic [9:0]  pend_bits_reg, pend_bits_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        discard_reg, discard_next;

    logic        is_high, is_low, is_nonchar;
    logic [20:0] code_point;
    logic [7:0]  cu_lo8;

    assign is_high    = (code_unit >= SURR_HIGH_LO) && (code_unit <= SURR_HIGH_HI);
    assign is_low     = (code_unit >= SURR_LOW_LO) && (code_unit <= SURR_LOW_HI);
    assign is_nonchar = (code_unit == NONCHAR_FFFE) || (code_unit == NONCHAR_FFFF);
    assign code_point = {{1'b0, pend_bits_reg} + PLANE_OFFSET, code_unit[9:0]};
    assign cu_lo8     = code_unit[7:0];

    always_comb begin
        pend_bits_next  = pend_bits_reg;
        pend_valid_next = pend_valid_reg;
        discard_next    = discard_reg;
        group.bytes     = '0;
        group.count     = '0;
        group.last      = last_unit;
        group.err       = 1'b0;
        if (accept) begin
            if (discard_reg) begin
                // drop the rest of a rejected string
                if (last_unit) begin
                    discard_next = 1'b0;
                end
            end else if ((pend_valid_reg && !is_low) || (!pend_valid_reg && is_high && last_unit)
                         || (!pend_valid_reg && (is_low || is_nonchar))) begin
                pend_valid_next = 1'b0;
                pend_bits_next  = '0;
                discard_next    = !last_unit;
                group.count     = CNT_W'(1);
                group.last      = 1'b1;
                group.err       = 1'b1;
            end else if (pend_valid_reg) begin
                group.bytes[0]  = LEAD_4BYTE | {5'd0, code_point[20:18]};
                group.bytes[1]  = CONT_BYTE | {2'd0, code_point[17:12]};
                group.bytes[2]  = CONT_BYTE | {2'd0, code_point[11:6]};
                group.bytes[3]  = CONT_BYTE | {2'd0, code_point[5:0]};
                group.count     = CNT_W'(4);
                pend_valid_next = 1'b0;
                pend_bits_next  = '0;
            end else if (is_high) begin
                // hold until the low half arrives
                pend_bits_next  = code_unit[9:0];
                pend_valid_next = 1'b1;
            end else if (code_unit < LIMIT_1BYTE) begin
                group.bytes[0] = cu_lo8;
                group.count    = CNT_W'(1);
            end else if (code_unit < LIMIT_2BYTE) begin
                group.bytes[0] = LEAD_2BYTE | {3'd0, code_unit[10:6]};
                group.bytes[1] = CONT_BYTE | {2'd0, code_unit[5:0]};
                group.count    = CNT_W'(2);
            end else begin
                group.bytes[0] = LEAD_3BYTE | {4'd0, code_unit[15:12]};
                group.bytes[1] = CONT_BYTE | {2'd0, code_unit[11:6]};
                group.bytes[2] = CONT_BYTE | {2'd0, code_unit[5:0]};
                group.count    = CNT_W'(3);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg  <= '0;
            pend_valid_reg <= 1'b0;
            discard_reg    <= 1'b0;
        end else begin
            pend_bits_reg  <= pend_bits_next;
            pend_valid_reg <= pend_valid_next;
            discard_reg    <= discard_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utf16_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_code_unit[15:0], s_last_unit
// m_       out  m_valid/m_ready    m_out_byte[7:0], m_end_of_string, m_error
//
// A code unit is encoded in the cycle it is accepted and its 0..4 bytes are
// parked in a group register; the group drains one byte per cycle into the
// output register while m_ready does not stall it.
// The next unit is taken in the cycle the last byte of the group leaves.
// Reset (aresetn low, synchronous) clears the held surrogate, the drop flag
// and both valid paths. A stall on m_ready holds the output beat and backs up
// into s_ready once the group register is full.

module utf16_to_utf8_transcoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_code_unit,
    input  wire logic        s_last_unit,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_end_of_string,
    output logic             m_error
);
    import u16u8_pkg::*;

    group_t                    enc_group;
    logic                      s_fire, out_load;

    logic [MAX_BYTES-1:0][7:0] grp_bytes_reg;
    logic [CNT_W-1:0]          grp_cnt_reg, grp_cnt_next;
    logic [IDX_W-1:0]          grp_idx_reg, grp_idx_next;
    logic                      grp_last_reg;
    logic                      grp_err_reg;

    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_byte_reg;
    logic                      m_end_reg;
    logic                      m_err_reg;

    assign out_load = (grp_cnt_reg != '0) && (!m_valid_reg || m_ready);
    assign s_ready  = (grp_cnt_reg == '0) || (out_load && grp_cnt_reg == CNT_W'(1));
    assign s_fire   = s_valid && s_ready;

    u16u8_encoder u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_fire),
        .code_unit (s_code_unit),
        .last_unit (s_last_unit),
        .group     (enc_group)
    );

    always_comb begin
        grp_cnt_next = grp_cnt_reg;
        grp_idx_next = grp_idx_reg;
        if (out_load) begin
            grp_cnt_next = grp_cnt_reg - CNT_W'(1);
            grp_idx_next = grp_idx_reg + IDX_W'(1);
        end
        if (s_fire) begin
            grp_cnt_next = enc_group.count;
            grp_idx_next = '0;
        end
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_cnt_reg <= '0;
            grp_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            grp_cnt_reg <= grp_cnt_next;
            grp_idx_reg <= grp_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            grp_bytes_reg <= enc_group.bytes;
            grp_last_reg  <= enc_group.last;
            grp_err_reg   <= enc_group.err;
        end
        if (out_load) begin
            m_byte_reg <= grp_bytes_reg[grp_idx_reg];
            // end flag only on the final byte of the group
            m_end_reg  <= grp_last_reg && (grp_cnt_reg == CNT_W'(1));
            m_err_reg  <= grp_err_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_end_of_string = m_end_reg;
    assign m_error         = m_err_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/u16u8_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u16u8_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_end_of_string,
    input wire logic       m_error
);

    // an error beat is a bare terminator
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_out_byte == 8'h00 && m_end_of_string))
        else $error("error beat carries data or lacks end mark");

    // no overlong lead bytes and nothing past the Unicode range
    a_legal_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_error) |->
        (m_out_byte != 8'hC0 && m_out_byte != 8'hC1 && m_out_byte < 8'hF5))
        else $error("illegal UTF-8 byte emitted");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_out_byte) && $stable(m_end_of_string) && $stable(m_error)))
        else $error("stalled result beat changed");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_byte      (m_out_byte),
    .m_end_of_string (m_end_of_string),
    .m_error         (m_error)
);

`default_nettype wire

// ===== tb/utf16_to_utf8_transcoder_tb.sv =====
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_tb;

    import u16u8_pkg::*;

    localparam int RANDOM_UNITS  = 445;
    localparam int RX_STALL_AT   = 200;
    localparam int RX_STALL_LEN  = 150;
    localparam int IDLE_LIMIT    = 1000;
    localparam int TAIL_CYCLES   = 16;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
        logic        drain;
    } unit_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       err;
    } utf8_beat_t;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit     = '0;
    logic        s_last_unit     = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_end_of_string;
    logic        m_error;

    unit_item_t  unit_q[$];
    utf8_beat_t  utf8_expect_q[$];

    // predictor state
    logic [9:0]  held_bits  = '0;
    logic        held_valid = 1'b0;
    logic        dropping   = 1'b0;

    int          errors      = 0;
    int          n_queued    = 0;
    int          tx_wait     = 0;
    int          tx_sent     = 0;
    int          rx_wait     = 0;
    int          rx_beats    = 0;
    int          idle_cycles = 0;

    // driver / monitor scratch
    logic        nxt_valid = 1'b0;
    int          nxt_wait;
    unit_item_t  nxt_item;
    int          rx_gap;
    utf8_beat_t  want;

    utf16_to_utf8_transcoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_unit     (s_code_unit),
        .s_last_unit     (s_last_unit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_end_of_string (m_end_of_string),
        .m_error         (m_error)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void expect_byte(input logic [7:0] data, input logic eos,
                                        input logic err);
        utf8_beat_t b;
        b.data = data;
        b.eos  = eos;
        b.err  = err;
        utf8_expect_q.push_back(b);
    endfunction

    function automatic void reject_string(input logic last);
        held_valid = 1'b0;
        held_bits  = '0;
        dropping   = !last;
        expect_byte(8'h00, 1'b1, 1'b1);
    endfunction

    function automatic void transcode_unit(input logic [15:0] cu, input logic last);
        logic        is_high;
        logic        is_low;
        logic [20:0] cp;
        is_high = (cu >= SURR_HIGH_LO) && (cu <= SURR_HIGH_HI);
        is_low  = (cu >= SURR_LOW_LO) && (cu <= SURR_LOW_HI);
        if (dropping) begin
            if (last)
                dropping = 1'b0;
        end else if (held_valid) begin
            if (!is_low) begin
                reject_string(last);
            end else begin
                cp = 21'h10000 + {1'b0, held_bits, cu[9:0]};
                expect_byte(LEAD_4BYTE | {5'b0, cp[20:18]}, 1'b0, 1'b0);
                expect_byte(CONT_BYTE | {2'b0, cp[17:12]}, 1'b0, 1'b0);
                expect_byte(CONT_BYTE | {2'b0, cp[11:6]}, 1'b0, 1'b0);
                expect_byte(CONT_BYTE | {2'b0, cp[5:0]}, last, 1'b0);
                held_valid = 1'b0;
                held_bits  = '0;
            end
        end else if (is_high) begin
            if (last) begin
                reject_string(last);
            end else begin
                held_bits  = cu[9:0];
                held_valid = 1'b1;
            end
        end else if (is_low || cu == NONCHAR_FFFE || cu == NONCHAR_FFFF) begin
            reject_string(last);
        end else if (cu < LIMIT_1BYTE) begin
            expect_byte(cu[7:0], last, 1'b0);
        end else if (cu < LIMIT_2BYTE) begin
            expect_byte(LEAD_2BYTE | {3'b0, cu[10:6]}, 1'b0, 1'b0);
            expect_byte(CONT_BYTE | {2'b0, cu[5:0]}, last, 1'b0);
        end else begin
            expect_byte(LEAD_3BYTE | {4'b0, cu[15:12]}, 1'b0, 1'b0);
            expect_byte(CONT_BYTE | {2'b0, cu[11:6]}, 1'b0, 1'b0);
            expect_byte(CONT_BYTE | {2'b0, cu[5:0]}, last, 1'b0);
        end
    endfunction

    function automatic void add_unit(input logic [15:0] code, input logic last,
                                     input logic drain);
        unit_item_t it;
        it.code  = code;
        it.last  = last;
        it.drain = drain;
        unit_q.push_back(it);
        n_queued++;
    endfunction

    // driver: offer queued units, random gap after each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            nxt_valid = s_valid;
            nxt_wait  = tx_wait;
            if (s_valid && s_ready) begin
                transcode_unit(s_code_unit, s_last_unit);
                tx_sent  <= tx_sent + 1;
                nxt_valid = 1'b0;
                nxt_wait  = (((tx_sent / 32) % 3) == 1) ? 0 : $urandom_range(0, 14);
            end
            if (!nxt_valid) begin
                if (nxt_wait != 0) begin
                    nxt_wait = nxt_wait - 1;
                end else if (unit_q.size() != 0 &&
                             (!unit_q[0].drain || utf8_expect_q.size() == 0)) begin
                    nxt_item     = unit_q.pop_front();
                    nxt_valid    = 1'b1;
                    s_code_unit <= nxt_item.code;
                    s_last_unit <= nxt_item.last;
                end
            end
            s_valid <= nxt_valid;
            tx_wait <= nxt_wait;
        end
    end

    // monitor: check each output beat, then hold off ready for a random gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (utf8_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat byte %h end %b err %b", $time,
                         m_out_byte, m_end_of_string, m_error);
            end else begin
                want = utf8_expect_q.pop_front();
                if (m_out_byte !== want.data || m_end_of_string !== want.eos ||
                    m_error !== want.err) begin
                    errors++;
                    $display("%0t: expected byte %h end %b err %b, got byte %h end %b err %b",
                             $time, want.data, want.eos, want.err,
                             m_out_byte, m_end_of_string, m_error);
                end
            end
            rx_beats <= rx_beats + 1;
            if (rx_beats == RX_STALL_AT)
                rx_gap = RX_STALL_LEN;
            else if (((rx_beats / 48) % 3) == 2)
                rx_gap = 0;
            else
                rx_gap = $urandom_range(0, 14);
            rx_wait <= rx_gap;
            m_ready <= (rx_gap == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: abort when no beat moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("utf16_to_utf8_transcoder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int          len;
        int          k;
        int          sel;
        int          strings;
        logic [15:0] cu;
        logic        drain;

        // range boundaries of each encoding length
        add_unit(16'h0041, 1'b0, 1'b0);
        add_unit(16'h0000, 1'b0, 1'b0);
        add_unit(16'h007F, 1'b0, 1'b0);
        add_unit(16'h0080, 1'b0, 1'b0);
        add_unit(16'h07FF, 1'b0, 1'b0);
        add_unit(16'h0800, 1'b0, 1'b0);
        add_unit(16'hD7FF, 1'b0, 1'b0);
        add_unit(16'hE000, 1'b0, 1'b0);
        add_unit(16'hFFFD, 1'b1, 1'b0);
        // lowest and highest surrogate pairs
        add_unit(SURR_HIGH_LO, 1'b0, 1'b0);
        add_unit(SURR_LOW_LO, 1'b1, 1'b0);
        add_unit(SURR_HIGH_HI, 1'b0, 1'b0);
        add_unit(SURR_LOW_HI, 1'b0, 1'b0);
        add_unit(16'h0024, 1'b1, 1'b0);
        // lone low surrogate opening a string, rest of string dropped
        add_unit(SURR_LOW_LO, 1'b0, 1'b0);
        add_unit(16'h0041, 1'b0, 1'b0);
        add_unit(16'h0042, 1'b1, 1'b0);
        // high surrogate followed by a plain unit
        add_unit(16'hD834, 1'b0, 1'b0);
        add_unit(16'h0041, 1'b1, 1'b0);
        // high surrogate closing the string
        add_unit(SURR_HIGH_HI, 1'b1, 1'b0);
        // noncharacters
        add_unit(NONCHAR_FFFE, 1'b1, 1'b0);
        add_unit(NONCHAR_FFFF, 1'b0, 1'b0);
        add_unit(16'h0043, 1'b1, 1'b0);
        // high surrogate followed by another high one
        add_unit(SURR_HIGH_LO, 1'b0, 1'b0);
        add_unit(16'hD801, 1'b1, 1'b0);

        strings = 0;
        while (n_queued < 25 + RANDOM_UNITS) begin
            len   = $urandom_range(1, 8);
            drain = (strings % 15) == 0;
            k     = 0;
            while (k < len) begin
                sel = $urandom_range(0, 99);
                if (sel < 22) begin
                    cu = 16'($urandom_range(16'h0000, 16'h007F));
                end else if (sel < 40) begin
                    cu = 16'($urandom_range(16'h0080, 16'h07FF));
                end else if (sel < 64) begin
                    do
                        cu = 16'($urandom_range(16'h0800, 16'hFFFD));
                    while (cu >= SURR_HIGH_LO && cu <= SURR_LOW_HI);
                end else if (sel < 86) begin
                    // well-formed pair: hold the mark for the low half
                    cu = 16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI));
                    add_unit(cu, 1'b0, drain);
                    drain = 1'b0;
                    k++;
                    cu = 16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI));
                end else if (sel < 90) begin
                    cu = 16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI));
                end else if (sel < 94) begin
                    cu = 16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI));
                end else if (sel < 96) begin
                    cu = $urandom_range(0, 1) ? NONCHAR_FFFF : NONCHAR_FFFE;
                end else begin
                    cu = 16'($urandom());
                end
                add_unit(cu, k >= len - 1, drain);
                drain = 1'b0;
                k++;
            end
            strings++;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (unit_q.size() != 0 || s_valid || nxt_valid)
            @(posedge aclk);
        while (utf8_expect_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("utf16_to_utf8_transcoder: match");
        else
            $display("utf16_to_utf8_transcoder: mismatch");
        $finish;
    end

endmodule
